// ===== design/pts_pkg.sv =====
// package for the priority task scheduler
// types, codes and fixed field widths shared by all design files
`default_nettype none

package pts_pkg;

   localparam int CMD_W     = 2;
   localparam int PRIO_W    = 4;
   localparam int DELAY_W   = 16;
   localparam int ACTION_W  = 3;
   localparam int TASK_ID_W = 3;
   localparam int TOTAL_W   = 4;

   localparam logic [PRIO_W-1:0] PRIO_IDLE = 4'd15;
   localparam logic [PRIO_W:0]   PRIO_NONE = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_CREATE = 2'd1,
      CMD_DELAY  = 2'd2,
      CMD_SCHED  = 2'd3
   } cmd_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_RESUME  = 3'd2,
      ACT_REJECT  = 3'd3,
      ACT_CREATED = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      TS_READY     = 3'd0,
      TS_RUNNING   = 3'd1,
      TS_SUSPENDED = 3'd2,
      TS_BLOCKED   = 3'd3,
      TS_UNBLOCKED = 3'd4
   } task_state_type;

   typedef enum logic [2:0] {
      SCH_INIT,
      SCH_IDLE,
      SCH_WALK,
      SCH_FINISH,
      SCH_RESULT
   } sched_state_type;

   // write enables and read strobe for the task table
   typedef struct packed {
      logic sw_we;
      logic prio_we;
      logic rd_en;
   } tbl_ctl_type;

endpackage

`default_nettype wire

// ===== design/pts_if.sv =====
// valid/ready channel interfaces for the scheduler command and response words
// depends on pts_pkg for field widths
`default_nettype none

interface pts_req_if;
   import pts_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [PRIO_W-1:0]   task_priority;
   logic [DELAY_W-1:0]  delay_ticks;

   modport source (output valid, cmd, task_priority, delay_ticks, input ready);
   modport sink (input valid, cmd, task_priority, delay_ticks, output ready);
endinterface

interface pts_rsp_if;
   import pts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [TASK_ID_W-1:0] current_task;
   logic [TASK_ID_W-1:0] created_task;
   logic [TOTAL_W-1:0]   task_total;

   modport source (output valid, action, current_task, created_task, task_total,
                   input ready);
   modport sink (input valid, action, current_task, created_task, task_total,
                 output ready);
endinterface

`default_nettype wire

// ===== design/priority_task_scheduler.sv =====
// fixed-priority preemptive scheduler: top level with command sequencer
// depends on pts_pkg, pts_if and pts_table
//
// Usage: commands arrive as words on req_bus (valid/ready), one response word
// per command leaves on rsp_bus (valid/ready). Commands are tick, create task,
// delay current task then schedule, and schedule pass.
// Tick and create go from SCH_IDLE to SCH_RESULT, which loads the response register once it is free.
// Delay and schedule walk the task table through the single read port of the
// table memory, one entry per cycle, pipelined with the write-back of the
// previous entry, then pass through SCH_FINISH to SCH_RESULT.
// One command is processed at a time; req_bus.ready is high while the
// sequencer is idle, in the cycle after the response word is loaded, and the
// next word is taken while a response still waits.
// A response that is not taken holds in the output register, and a later
// result waits in the sequencer until that register drains.
// Reset is synchronous: the tick counter clears, the table holds only the idle
// task, and after reset SCH_INIT writes entry 0 before ready rises.
`default_nettype none

module priority_task_scheduler #(
   parameter int MAX_TASKS  = 8,
   parameter int TICK_WIDTH = 32
) (
   input  wire        clock,
   input  wire        reset,
   pts_req_if.sink    req_bus,
   pts_rsp_if.source  rsp_bus
);
   import pts_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   sched_state_type        state_ff, state_in;
   logic [TICK_WIDTH-1:0]  tick_ff, tick_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       current_ff, current_in;
   logic [IDX_W-1:0]       chosen_ff, chosen_in;
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                   ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]       ev_idx_ff, ev_idx_in;
   logic [PRIO_W:0]        best_ff, best_in;
   logic                   found_ff, found_in;
   task_state_type         sel_state_ff, sel_state_in;
   logic [TICK_WIDTH-1:0]  sel_wake_ff, sel_wake_in;
   action_type             act_ff, act_in;
   logic [IDX_W-1:0]       created_ff, created_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   action_type             rsp_action_ff, rsp_action_in;
   logic [TASK_ID_W-1:0]   rsp_current_ff, rsp_current_in;
   logic [TASK_ID_W-1:0]   rsp_created_ff, rsp_created_in;
   logic [TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;

   tbl_ctl_type            tbl_ctl;
   logic [IDX_W-1:0]       wr_addr;
   task_state_type         wr_state;
   logic [TICK_WIDTH-1:0]  wr_wake;
   logic [PRIO_W-1:0]      wr_prio;
   logic [IDX_W-1:0]       rd_addr;
   task_state_type         rd_state;
   logic [TICK_WIDTH-1:0]  rd_wake;
   logic [PRIO_W-1:0]      rd_prio;

   task_state_type         ev_state;
   logic                   ev_elig;
   logic                   out_free;
   cmd_type                cmd;

   pts_table #(
      .MAX_TASKS  (MAX_TASKS),
      .TICK_WIDTH (TICK_WIDTH)
   ) u_table (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .wr_addr  (wr_addr),
      .wr_state (wr_state),
      .wr_wake  (wr_wake),
      .wr_prio  (wr_prio),
      .rd_addr  (rd_addr),
      .rd_state (rd_state),
      .rd_wake  (rd_wake),
      .rd_prio  (rd_prio)
   );

   assign cmd      = cmd_type'(req_bus.cmd);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // entry under evaluation: suspend the running task, wake due sleepers
   always_comb begin
      ev_state = rd_state;
      if (ev_idx_ff == current_ff && rd_state == TS_RUNNING) begin
         ev_state = TS_SUSPENDED;
      end
      if (ev_state == TS_BLOCKED && tick_ff >= rd_wake) begin
         ev_state = TS_UNBLOCKED;
      end
      ev_elig = ev_state inside {TS_READY, TS_SUSPENDED, TS_UNBLOCKED};
   end

   always_comb begin
      state_in       = state_ff;
      tick_in        = tick_ff;
      count_in       = count_ff;
      current_in     = current_ff;
      chosen_in      = chosen_ff;
      rd_cnt_in      = rd_cnt_ff;
      ev_vld_in      = 1'b0;
      ev_idx_in      = ev_idx_ff;
      best_in        = best_ff;
      found_in       = found_ff;
      sel_state_in   = sel_state_ff;
      sel_wake_in    = sel_wake_ff;
      act_in         = act_ff;
      created_in     = created_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_action_in  = rsp_action_ff;
      rsp_current_in = rsp_current_ff;
      rsp_created_in = rsp_created_ff;
      rsp_total_in   = rsp_total_ff;
      tbl_ctl        = '0;
      wr_addr        = '0;
      wr_state       = TS_READY;
      wr_wake        = '0;
      wr_prio        = PRIO_IDLE;
      rd_addr        = rd_cnt_ff[IDX_W-1:0];
      req_bus.ready  = 1'b0;

      case (state_ff)
         SCH_INIT: begin
            tbl_ctl.sw_we   = 1'b1;
            tbl_ctl.prio_we = 1'b1;
            state_in        = SCH_IDLE;
         end

         SCH_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               rd_cnt_in  = '0;
               best_in    = PRIO_NONE;
               found_in   = 1'b0;
               act_in     = ACT_NONE;
               created_in = '0;
               case (cmd)
                  CMD_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     state_in = SCH_RESULT;
                  end
                  CMD_CREATE: begin
                     if (count_ff >= CNT_W'(MAX_TASKS)) begin
                        act_in = ACT_REJECT;
                     end else begin
                        tbl_ctl.sw_we   = 1'b1;
                        tbl_ctl.prio_we = 1'b1;
                        wr_addr         = count_ff[IDX_W-1:0];
                        wr_prio         = req_bus.task_priority;
                        created_in      = count_ff[IDX_W-1:0];
                        count_in        = count_ff + 1'b1;
                        act_in          = ACT_CREATED;
                     end
                     state_in = SCH_RESULT;
                  end
                  CMD_DELAY: begin
                     tbl_ctl.sw_we = 1'b1;
                     wr_addr       = current_ff;
                     wr_state      = TS_BLOCKED;
                     wr_wake       = tick_ff + TICK_WIDTH'(req_bus.delay_ticks);
                     state_in      = SCH_WALK;
                  end
                  default: begin
                     state_in = SCH_WALK;
                  end
               endcase
            end
         end

         SCH_WALK: begin
            // read entry n while entry n-1 is evaluated and written back
            if (rd_cnt_ff < count_ff) begin
               tbl_ctl.rd_en = 1'b1;
               rd_cnt_in     = rd_cnt_ff + 1'b1;
               ev_vld_in     = 1'b1;
               ev_idx_in     = rd_cnt_ff[IDX_W-1:0];
            end
            if (ev_vld_ff) begin
               tbl_ctl.sw_we = 1'b1;
               wr_addr       = ev_idx_ff;
               wr_state      = ev_state;
               wr_wake       = rd_wake;
               if (ev_elig && {1'b0, rd_prio} < best_ff) begin
                  best_in      = {1'b0, rd_prio};
                  chosen_in    = ev_idx_ff;
                  found_in     = 1'b1;
                  sel_state_in = ev_state;
                  sel_wake_in  = rd_wake;
               end else if (!found_ff && ev_idx_ff == chosen_ff) begin
                  sel_state_in = ev_state;
                  sel_wake_in  = rd_wake;
               end
               if (rd_cnt_ff >= count_ff) begin
                  state_in = SCH_FINISH;
               end
            end
         end

         SCH_FINISH: begin
            case (sel_state_ff)
               TS_READY: begin
                  act_in = ACT_START;
               end
               TS_SUSPENDED, TS_UNBLOCKED: begin
                  act_in = ACT_RESUME;
               end
               default: begin
                  act_in = ACT_NONE;
               end
            endcase
            if (sel_state_ff inside {TS_READY, TS_SUSPENDED, TS_UNBLOCKED}) begin
               tbl_ctl.sw_we = 1'b1;
               wr_addr       = chosen_ff;
               wr_state      = TS_RUNNING;
               wr_wake       = sel_wake_ff;
               current_in    = chosen_ff;
            end
            state_in = SCH_RESULT;
         end

         SCH_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_action_in  = act_ff;
               rsp_current_in = TASK_ID_W'(current_ff);
               rsp_created_in = TASK_ID_W'(created_ff);
               rsp_total_in   = TOTAL_W'(count_ff);
               state_in       = SCH_IDLE;
            end
         end

         default: begin
            state_in = SCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCH_INIT;
         tick_ff      <= '0;
         count_ff     <= CNT_W'(1);
         current_ff   <= '0;
         chosen_ff    <= '0;
         ev_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         chosen_ff    <= chosen_in;
         ev_vld_ff    <= ev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff      <= rd_cnt_in;
      ev_idx_ff      <= ev_idx_in;
      best_ff        <= best_in;
      found_ff       <= found_in;
      sel_state_ff   <= sel_state_in;
      sel_wake_ff    <= sel_wake_in;
      act_ff         <= act_in;
      created_ff     <= created_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_current_ff <= rsp_current_in;
      rsp_created_ff <= rsp_created_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.action       = rsp_action_ff;
   assign rsp_bus.current_task = rsp_current_ff;
   assign rsp_bus.created_task = rsp_created_ff;
   assign rsp_bus.task_total   = rsp_total_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count out of range");

   a_current_in_table: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(current_ff) < count_ff)
      else $error("current task outside the table");

   a_chosen_in_table: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(chosen_ff) < count_ff)
      else $error("chosen task outside the table");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      ev_vld_ff |-> (state_ff == SCH_WALK && CNT_W'(ev_idx_ff) < count_ff))
      else $error("table walk evaluates an entry outside the table");

endmodule

`default_nettype wire

// ===== design/pts_table.sv =====
// task table storage: state and wake tick in one memory, priority in another
// one write port each, shared read address, registered read data; uses pts_pkg
`default_nettype none

module pts_table #(
   parameter int MAX_TASKS  = 8,
   parameter int TICK_WIDTH = 32
) (
   input  wire                                 clock,
   input  pts_pkg::tbl_ctl_type                ctl,
   input  wire [$clog2(MAX_TASKS)-1:0]         wr_addr,
   input  pts_pkg::task_state_type             wr_state,
   input  wire [TICK_WIDTH-1:0]                wr_wake,
   input  wire [pts_pkg::PRIO_W-1:0]           wr_prio,
   input  wire [$clog2(MAX_TASKS)-1:0]         rd_addr,
   output pts_pkg::task_state_type             rd_state,
   output logic [TICK_WIDTH-1:0]               rd_wake,
   output logic [pts_pkg::PRIO_W-1:0]          rd_prio
);
   import pts_pkg::*;

   typedef struct packed {
      task_state_type        st;
      logic [TICK_WIDTH-1:0] wake;
   } sw_entry_type;

   sw_entry_type          sw_mem [MAX_TASKS];
   logic [PRIO_W-1:0]     prio_mem [MAX_TASKS];
   sw_entry_type          sw_rd_ff;
   logic [PRIO_W-1:0]     prio_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.sw_we) begin
         sw_mem[wr_addr] <= '{st: wr_state, wake: wr_wake};
      end
      if (ctl.rd_en) begin
         sw_rd_ff <= sw_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prio_we) begin
         prio_mem[wr_addr] <= wr_prio;
      end
      if (ctl.rd_en) begin
         prio_rd_ff <= prio_mem[rd_addr];
      end
   end

   assign rd_state = sw_rd_ff.st;
   assign rd_wake  = sw_rd_ff.wake;
   assign rd_prio  = prio_rd_ff;

endmodule

`default_nettype wire

// ===== tb/pts_checker.sv =====
// response checker for the priority task scheduler testbench
// keeps its own copy of the task table, predicts every response word and compares
// depends on pts_pkg and pts_if
`default_nettype none

module pts_checker #(
   parameter int MAX_TASKS  = 8,
   parameter int TICK_WIDTH = 32
) (
   input  wire  clock,
   input  wire  reset,
   pts_req_if   req_mon,
   pts_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   rsp_checked,
   output int   start_count,
   output int   resume_count,
   output int   wake_count,
   output int   reject_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   typedef struct packed {
      action_type           action;
      logic [TASK_ID_W-1:0] current;
      logic [TASK_ID_W-1:0] created;
      logic [TOTAL_W-1:0]   total;
   } decision_type;

   task_state_type        task_st   [MAX_TASKS];
   logic [PRIO_W-1:0]     task_pr   [MAX_TASKS];
   logic [TICK_WIDTH-1:0] task_wake [MAX_TASKS];
   int unsigned           table_size;
   int unsigned           running_idx;
   int unsigned           pick_idx;
   logic [TICK_WIDTH-1:0] tick_now;

   decision_type decision_q [$];
   int errors, checked, starts, resumes, wakes, rejects;

   function automatic void clear_table();
      for (int i = 0; i < MAX_TASKS; i++) begin
         task_st[i]   = TS_READY;
         task_pr[i]   = '0;
         task_wake[i] = '0;
      end
      task_pr[0]  = PRIO_IDLE;
      table_size  = 1;
      running_idx = 0;
      pick_idx    = 0;
      tick_now    = '0;
   endfunction

   function automatic bit can_run(task_state_type s);
      return s == TS_READY || s == TS_SUSPENDED || s == TS_UNBLOCKED;
   endfunction

   // suspend the running task, wake due sleepers, pick lowest priority number
   function automatic action_type pick_next_task();
      logic [PRIO_W:0] best;
      best = PRIO_NONE;
      if (task_st[running_idx] == TS_RUNNING)
         task_st[running_idx] = TS_SUSPENDED;
      for (int i = 0; i < table_size && i < MAX_TASKS; i++) begin
         if (task_st[i] == TS_BLOCKED && tick_now >= task_wake[i]) begin
            task_st[i] = TS_UNBLOCKED;
            wakes++;
         end
         if (can_run(task_st[i]) && {1'b0, task_pr[i]} < best) begin
            best     = {1'b0, task_pr[i]};
            pick_idx = i;
         end
      end
      case (task_st[pick_idx])
         TS_READY: begin
            running_idx = pick_idx;
            task_st[running_idx] = TS_RUNNING;
            return ACT_START;
         end
         TS_SUSPENDED, TS_UNBLOCKED: begin
            running_idx = pick_idx;
            task_st[running_idx] = TS_RUNNING;
            return ACT_RESUME;
         end
         default: return ACT_NONE;
      endcase
   endfunction

   function automatic decision_type predict_decision(cmd_type cmd, logic [PRIO_W-1:0] pr,
                                                     logic [DELAY_W-1:0] dl);
      decision_type d;
      int unsigned  new_idx;
      d.action = ACT_NONE;
      new_idx  = 0;
      case (cmd)
         CMD_TICK: tick_now = tick_now + 1'b1;
         CMD_CREATE: begin
            if (table_size >= MAX_TASKS) begin
               d.action = ACT_REJECT;
            end else begin
               new_idx            = table_size;
               task_st[new_idx]   = TS_READY;
               task_pr[new_idx]   = pr;
               task_wake[new_idx] = '0;
               table_size++;
               d.action = ACT_CREATED;
            end
         end
         CMD_DELAY: begin
            task_st[running_idx]   = TS_BLOCKED;
            task_wake[running_idx] = tick_now + dl;
            d.action = pick_next_task();
         end
         default: d.action = pick_next_task();
      endcase
      d.current = TASK_ID_W'(running_idx);
      d.created = TASK_ID_W'(new_idx);
      d.total   = TOTAL_W'(table_size);
      return d;
   endfunction

   task automatic compare_field(input string label, input logic [3:0] want,
                                input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
         errors++;
      end
   endtask

   task automatic check_response();
      decision_type exp;
      if (decision_q.size() == 0) begin
         $display("%0t: response word with nothing expected, expected none, got action %0d",
                  $time, rsp_mon.action);
         errors++;
      end else begin
         exp = decision_q[0];
         decision_q.delete(0);
         compare_field("action", exp.action, rsp_mon.action);
         compare_field("current_task", exp.current, rsp_mon.current_task);
         compare_field("created_task", exp.created, rsp_mon.created_task);
         compare_field("task_total", exp.total, rsp_mon.task_total);
         checked++;
      end
   endtask

   always @(posedge clock) begin
      decision_type d;
      if (reset) begin
         clear_table();
         decision_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_response();
         if (req_mon.valid && req_mon.ready) begin
            d = predict_decision(cmd_type'(req_mon.cmd), req_mon.task_priority,
                                 req_mon.delay_ticks);
            case (d.action)
               ACT_START:  starts++;
               ACT_RESUME: resumes++;
               ACT_REJECT: rejects++;
               default: ;
            endcase
            decision_q.push_back(d);
         end
      end
      fail_count   <= errors;
      outstanding  <= decision_q.size();
      rsp_checked  <= checked;
      start_count  <= starts;
      resume_count <= resumes;
      wake_count   <= wakes;
      reject_count <= rejects;
   end

endmodule

`default_nettype wire

// ===== tb/priority_task_scheduler_tb.sv =====
// top of the priority task scheduler testbench: clock, reset, command stimulus
// and response back-pressure; depends on pts_pkg, pts_if, the design and pts_checker
`default_nettype none

module priority_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam int TASK_SLOTS   = 8;
   localparam int TICK_BITS    = 32;
   localparam int RANDOM_WORDS = 800;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   int fail_count, outstanding, rsp_checked;
   int start_count, resume_count, wake_count, reject_count;
   int send_quiet, rsp_quiet, rsp_hold, sent, cycle_count;

   priority_task_scheduler #(
      .MAX_TASKS  (TASK_SLOTS),
      .TICK_WIDTH (TICK_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pts_checker #(
      .MAX_TASKS  (TASK_SLOTS),
      .TICK_WIDTH (TICK_BITS)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .rsp_checked  (rsp_checked),
      .start_count  (start_count),
      .resume_count (resume_count),
      .wake_count   (wake_count),
      .reject_count (reject_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response back-pressure, with occasional stretches of no stall
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
         rsp_quiet     <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_quiet > 0) begin
            stall = 0;
            rsp_quiet <= rsp_quiet - 1;
         end else if ($urandom_range(0, 15) == 0) begin
            stall = 0;
            rsp_quiet <= $urandom_range(10, 40);
         end else begin
            stall = $urandom_range(0, 19);
         end
         rsp_hold      <= stall;
         rsp_bus.ready <= (stall == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= (rsp_hold == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // valid stays high across back-to-back words; lowered only for a gap
   task automatic send_word(input cmd_type c, input logic [PRIO_W-1:0] p,
                            input logic [DELAY_W-1:0] d);
      int gap;
      if (send_quiet > 0) begin
         gap = 0;
         send_quiet--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         send_quiet = $urandom_range(10, 40);
      end else begin
         gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= c;
      req_bus.task_priority <= p;
      req_bus.delay_ticks   <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   initial begin
      int r;
      int q;
      cmd_type c;
      logic [DELAY_W-1:0] d;
      reset                 = 1'b1;
      send_quiet            = 0;
      sent                  = 0;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = CMD_TICK;
      req_bus.task_priority = '0;
      req_bus.delay_ticks   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // idle task alone: start, resume, sleep, nothing eligible, wake
      send_word(CMD_SCHED, 4'd0, 16'd0);
      send_word(CMD_SCHED, 4'd15, 16'hffff);
      send_word(CMD_DELAY, 4'd0, 16'd0);
      send_word(CMD_DELAY, 4'd0, 16'd3);
      send_word(CMD_SCHED, 4'd0, 16'd0);
      send_word(CMD_TICK, 4'd0, 16'd0);
      send_word(CMD_TICK, 4'd15, 16'hffff);
      send_word(CMD_TICK, 4'd0, 16'd0);
      send_word(CMD_SCHED, 4'd0, 16'd0);
      // priority tie with idle goes to the lower index
      send_word(CMD_CREATE, 4'd15, 16'd0);
      send_word(CMD_SCHED, 4'd0, 16'd0);
      send_word(CMD_CREATE, 4'd0, 16'd0);
      send_word(CMD_SCHED, 4'd0, 16'd0);
      send_word(CMD_DELAY, 4'd0, 16'hffff);
      send_word(CMD_CREATE, 4'd7, 16'd0);
      send_word(CMD_CREATE, 4'd7, 16'd0);
      send_word(CMD_SCHED, 4'd0, 16'd0);
      send_word(CMD_DELAY, 4'd0, 16'd2);
      send_word(CMD_TICK, 4'd0, 16'd0);
      send_word(CMD_TICK, 4'd0, 16'd0);
      send_word(CMD_SCHED, 4'd0, 16'd0);
      send_word(CMD_TICK, 4'd10, 16'h5555);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         r = $urandom_range(0, 99);
         d = 16'($urandom_range(0, 65535));
         if (r < 40) begin
            c = CMD_TICK;
         end else if (r < 55) begin
            c = CMD_CREATE;
         end else if (r < 75) begin
            c = CMD_DELAY;
            q = $urandom_range(0, 99);
            if (q < 85)
               d = 16'($urandom_range(0, 12));
            else if (q < 99)
               d = 16'($urandom_range(13, 60));
         end else begin
            c = CMD_SCHED;
         end
         send_word(c, 4'($urandom_range(0, 15)), d);
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d commands sent, %0d response words checked", sent, rsp_checked);
      $display("tb: %0d task starts, %0d resumes, %0d wakeups, %0d full-table rejects",
               start_count, resume_count, wake_count, reject_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
